// File: src/zxf_pkg.sv
// Package: shared types and constants of the ZIP64 extra field parser.
`timescale 1ns / 1ps

package zxf_pkg;

  localparam logic [15:0] ZIP64_RECORD_ID = 16'h0001;
  localparam int unsigned NUM_VALUES      = 3;

  // Parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_TARGET = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  // Value indexes; VAL_NONE marks a slot with no owner
  localparam logic [1:0] VAL_UNCOMPRESSED = 2'd0;
  localparam logic [1:0] VAL_COMPRESSED   = 2'd1;
  localparam logic [1:0] VAL_OFFSET       = 2'd2;
  localparam logic [1:0] VAL_NONE         = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       want_uncompressed_size;
    logic       want_compressed_size;
    logic       want_header_offset;
  } item_t;

  typedef struct packed {
    logic [63:0] uncompressed_size;
    logic        uncompressed_found;
    logic [63:0] compressed_size;
    logic        compressed_found;
    logic [63:0] header_offset;
    logic        offset_found;
    logic        record_found;
  } result_t;

  typedef struct packed {
    logic [1:0]                       phase;
    logic [15:0]                      byte_count;
    logic [15:0]                      record_id;
    logic [15:0]                      record_length;
    logic [NUM_VALUES-1:0]            want_flags;
    logic [NUM_VALUES-1:0]            got_flags;
    logic                             done_flag;
    logic [NUM_VALUES-1:0][63:0]      values;
  } parse_state_t;

endpackage

// File: src/zxf_stream_if.sv
// Interface: valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface zxf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/zxf_step.sv
// Next-state logic: advance the record walk by one byte and form the result.
`timescale 1ns / 1ps

module zxf_step (
  input  zxf_pkg::parse_state_t st,
  input  zxf_pkg::item_t        item,
  output zxf_pkg::parse_state_t st_next,
  output zxf_pkg::result_t      res
);

  // Value owning 8-byte slot s: the s-th wanted value in order.
  function automatic logic [1:0] slot_owner(input logic [2:0] want, input logic [1:0] s);
    logic [1:0] rank;
    logic [1:0] owner;
    rank  = 2'd0;
    owner = zxf_pkg::VAL_NONE;
    for (int i = 0; i < 3; i++) begin
      if (want[i]) begin
        if (rank == s && owner == zxf_pkg::VAL_NONE) owner = 2'(i);
        rank = rank + 2'd1;
      end
    end
    return owner;
  endfunction

  // Wanted values whose slot lies inside a record of the given slot count.
  function automatic logic [2:0] fitting_values(input logic [2:0] want,
                                                input logic [12:0] slots);
    logic [2:0] got;
    logic [1:0] rank;
    got  = 3'b000;
    rank = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (want[i]) begin
        got[i] = (slots > {11'd0, rank});
        rank   = rank + 2'd1;
      end
    end
    return got;
  endfunction

  logic [16:0] count_inc;
  logic        finish;
  logic [1:0]  owner;
  logic        slot_fits;
  logic [4:0]  slot_end;
  zxf_pkg::parse_state_t s;

  always_comb begin
    s = st;
    if (item.first_byte) begin
      s.phase         = zxf_pkg::PH_HEADER;
      s.byte_count    = '0;
      s.record_id     = '0;
      s.record_length = '0;
      s.want_flags    = {item.want_header_offset, item.want_compressed_size,
                         item.want_uncompressed_size};
      s.got_flags     = '0;
      s.done_flag     = 1'b0;
    end

    count_inc = {1'b0, s.byte_count} + 17'd1;
    finish    = 1'b0;
    slot_end  = {s.byte_count[4:3] + 2'd1, 3'b000};
    slot_fits = (s.byte_count[15:5] == 11'd0) && (s.byte_count[4:3] != 2'd3) &&
                ({11'd0, slot_end} <= s.record_length);
    owner     = slot_owner(s.want_flags, s.byte_count[4:3]);

    unique case (s.phase)
      zxf_pkg::PH_HEADER: begin
        unique case (s.byte_count[1:0])
          2'd0: s.record_id     = {8'h00, item.data_byte};
          2'd1: s.record_id     = {item.data_byte, s.record_id[7:0]};
          2'd2: s.record_length = {8'h00, item.data_byte};
          2'd3: s.record_length = {item.data_byte, s.record_length[7:0]};
          default: ;
        endcase
        if (s.byte_count[1:0] == 2'd3) begin
          s.byte_count = '0;
          if (s.record_id == zxf_pkg::ZIP64_RECORD_ID) begin
            if (s.record_length == 16'd0) finish = 1'b1;
            else                           s.phase = zxf_pkg::PH_TARGET;
          end else if (s.record_length != 16'd0) begin
            s.phase = zxf_pkg::PH_SKIP;
          end
        end else begin
          s.byte_count = count_inc[15:0];
        end
      end
      zxf_pkg::PH_SKIP: begin
        if (count_inc >= {1'b0, s.record_length}) begin
          s.byte_count = '0;
          s.phase      = zxf_pkg::PH_HEADER;
        end else begin
          s.byte_count = count_inc[15:0];
        end
      end
      zxf_pkg::PH_TARGET: begin
        if (slot_fits && owner != zxf_pkg::VAL_NONE)
          s.values[owner][{s.byte_count[2:0], 3'b000} +: 8] = item.data_byte;
        if (count_inc >= {1'b0, s.record_length}) finish = 1'b1;
        else                                      s.byte_count = count_inc[15:0];
      end
      zxf_pkg::PH_IDLE: ;
      default: ;
    endcase

    if (finish) begin
      s.got_flags  = fitting_values(s.want_flags, s.record_length[15:3]);
      s.done_flag  = 1'b1;
      s.phase      = zxf_pkg::PH_IDLE;
      s.byte_count = '0;
    end

    // Result as seen after this byte; zero every value not taken
    res.uncompressed_found = s.done_flag & s.got_flags[zxf_pkg::VAL_UNCOMPRESSED];
    res.compressed_found   = s.done_flag & s.got_flags[zxf_pkg::VAL_COMPRESSED];
    res.offset_found       = s.done_flag & s.got_flags[zxf_pkg::VAL_OFFSET];
    res.record_found       = s.done_flag;
    res.uncompressed_size  = res.uncompressed_found ? s.values[zxf_pkg::VAL_UNCOMPRESSED] : '0;
    res.compressed_size    = res.compressed_found   ? s.values[zxf_pkg::VAL_COMPRESSED]   : '0;
    res.header_offset      = res.offset_found       ? s.values[zxf_pkg::VAL_OFFSET]       : '0;

    // Field ended: drop everything until the next first byte
    if (item.last_byte) begin
      s.phase      = zxf_pkg::PH_IDLE;
      s.byte_count = '0;
      s.want_flags = '0;
      s.got_flags  = '0;
      s.done_flag  = 1'b0;
    end

    st_next = s;
  end

endmodule

// File: src/zip64_extra_field_parser.sv
// Top level: ZIP64 extended information extra field parser.
`timescale 1ns / 1ps

// Feed the bytes of one ZIP extra field, one byte per transaction, first_byte
// on the opening byte (which also latches the three want flags) and last_byte
// on the closing one. The block walks the little-endian id/length records and,
// inside the first id-1 record that fits wholly in the field, picks up the
// asked-for 64-bit sizes and header offset from consecutive 8-byte slots.
// Exactly one result transaction leaves for each byte marked last; other bytes
// give none. Throughput is one byte per clock while nothing stalls: the record
// walk is a short single-byte update between an input register and the parse
// state, so a new byte is taken every cycle. A result is registered into the
// result register when its held last byte advances; the input stalls only while
// a held last byte waits for the result channel to take the previous result.

module zip64_extra_field_parser (
  input  logic                 clk,
  input  logic                 rst,
  zxf_stream_if.sink           items,
  zxf_stream_if.source         results
);

  // Input register
  logic            s1_valid;
  zxf_pkg::item_t  s1_item;
  logic            s1_advance;

  // Parse state
  zxf_pkg::parse_state_t st;
  zxf_pkg::parse_state_t st_next;
  zxf_pkg::result_t      step_res;

  // Result register
  logic              out_valid;
  zxf_pkg::result_t  out_res;

  // Advance the held byte unless it carries a result and the result slot is
  // still occupied by one the sink has not taken.
  assign s1_advance  = s1_valid &&
                       (!s1_item.last_byte || !out_valid || results.ready);
  assign items.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) s1_item <= items.payload;
  end

  zxf_step u_step (
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .res     (step_res)
  );

  // Hold the parse state between bytes; the value registers need no reset
  // because a value is only reported once all eight of its bytes are written.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= zxf_pkg::PH_HEADER;
      st.byte_count    <= '0;
      st.record_id     <= '0;
      st.record_length <= '0;
      st.want_flags    <= '0;
      st.got_flags     <= '0;
      st.done_flag     <= 1'b0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_item.last_byte) out_res <= step_res;
  end

  assign results.valid   = out_valid;
  assign results.payload = out_res;

endmodule

// File: src/zxf_checker.sv
// Checker: port-level properties of the parser, bound to the top level.
`timescale 1ns / 1ps

module zxf_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input zxf_pkg::result_t out_payload
);

  // A stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A value can only be found inside a complete id-1 record
  a_found_needs_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_payload.uncompressed_found || out_payload.compressed_found ||
                  out_payload.offset_found) |-> out_payload.record_found)
    else $error("value found without a record");

  // Values not taken read as zero
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload.uncompressed_found || out_payload.uncompressed_size == 64'd0) &&
                  (out_payload.compressed_found || out_payload.compressed_size == 64'd0) &&
                  (out_payload.offset_found || out_payload.header_offset == 64'd0))
    else $error("missing value is not zero");

  // Input is never refused while nothing is held anywhere
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(!in_valid) && !$past(rst) |-> in_ready)
    else $error("input stalled while empty");

endmodule

bind zip64_extra_field_parser zxf_checker u_zxf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_payload (results.payload)
);
